// ----- rtl/lfs_pkg.sv -----
// shared types and constants of the line follow steering block
`default_nettype none

package lfs_pkg;

    localparam int SENSOR_COUNT = 6;
    localparam int SENSOR_W     = 10;
    localparam int LINE_POS_W   = 13;
    localparam int DIR_W        = 2;
    localparam int SPEED_W      = 10;
    localparam int TOP_W        = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    // sensor vector padded so fixed neighbor taps always exist
    localparam int EXT_W = (SENSOR_COUNT > 5) ? SENSOR_COUNT : 5;

    localparam int STEP_POS       = 1000;
    localparam int CENTRE_POS     = 2500;
    localparam int RIGHT_NONE_POS = 5000;
    localparam int LEFT_NONE_POS  = 0;
    localparam int CENTRE_LOW     = 2000;
    localparam int CENTRE_HIGH    = 3000;

    localparam int POS_MAX_A = (SENSOR_COUNT - 1) * STEP_POS;
    localparam int POS_MAX_B = (1 << LINE_POS_W) - 1;
    localparam int POS_MAX   = (POS_MAX_A > POS_MAX_B) ? POS_MAX_A : POS_MAX_B;
    localparam int POS_W     = $clog2(POS_MAX + 1);
    localparam int SUM_W     = POS_W + 1;

    localparam int IN_BITS     = DIR_W + SENSOR_COUNT * SENSOR_W + LINE_POS_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int LPOS_LSB    = DIR_W + SENSOR_COUNT * SENSOR_W;
    localparam int OUT_BITS    = 2 * SPEED_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [DIR_W-1:0] DIR_FOLLOW = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_KEEP   = 2'd3;

    localparam logic REQ_MODE   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM    = 2'd2;

    localparam logic [SENSOR_W-1:0]        RST_THRESHOLD = 10'd800;
    localparam logic [TOP_W-1:0]           RST_TOP       = 9'd200;
    localparam logic signed [SPEED_W-1:0]  RST_BOTTOM    = -10'sd200;

    typedef struct packed {
        logic             stop;
        logic [POS_W-1:0] pos;
    } steer_req_t;

    function automatic logic [POS_W-1:0] index_pos(input int idx);
        index_pos = POS_W'(idx * STEP_POS);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/line_follow_steering_top.sv -----
// top level of the line follow steering block
//
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tdata, s_tuser
// m_        out        m_tvalid / m_tready  m_tdata, m_tuser
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// two register stages: lane compare and merge, then steering into the output register
// accept, merge register, output register, then m_tvalid; one item per cycle sustained while m_tready is high
// mode writes produce no item but still take an input transfer
// a stall on m_tready backs up through both stages to s_tready
// synchronous active-low reset restores the default registers and follow mode
`default_nettype none

module line_follow_steering_top
    import lfs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // new_direction, sensor_0 .. sensor_5, line_position
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // left_speed, right_speed
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // intersection_stop
    output logic                        m_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SENSOR_W-1:0]        threshold_reg;
    logic [TOP_W-1:0]           top_reg;
    logic signed [SPEED_W-1:0]  bottom_reg;

    logic [SENSOR_COUNT-1:0]    on_line;
    logic                       mid_valid;
    logic                       mid_ready;
    steer_req_t                 mid_req;
    logic signed [SPEED_W-1:0]  left_speed;
    logic signed [SPEED_W-1:0]  right_speed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= RST_THRESHOLD;
            top_reg       <= RST_TOP;
            bottom_reg    <= RST_BOTTOM;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[SENSOR_W-1:0];
                CFG_TOP:       top_reg       <= cfg_data[TOP_W-1:0];
                CFG_BOTTOM:    bottom_reg    <= $signed(cfg_data[SPEED_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
        lfs_lane u_lane (
            .sensor    (s_tdata[DIR_W + i * SENSOR_W +: SENSOR_W]),
            .threshold (threshold_reg),
            .on_line   (on_line[i])
        );
    end

    lfs_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .req_type      (s_tuser),
        .new_direction (s_tdata[DIR_W-1:0]),
        .line_position (s_tdata[LPOS_LSB +: LINE_POS_W]),
        .on_line       (on_line),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_req       (mid_req)
    );

    lfs_steer u_steer (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (mid_valid),
        .in_ready          (mid_ready),
        .in_req            (mid_req),
        .top_speed         (top_reg),
        .bottom_speed      (bottom_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .left_speed        (left_speed),
        .right_speed       (right_speed),
        .intersection_stop (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({right_speed, left_speed});

endmodule

`default_nettype wire

// ----- rtl/lfs_lane.sv -----
// one sensor lane: on-line detection against the threshold
`default_nettype none

module lfs_lane
    import lfs_pkg::*;
(
    input  wire logic [SENSOR_W-1:0] sensor,
    input  wire logic [SENSOR_W-1:0] threshold,
    output logic                     on_line
);

    assign on_line = (sensor > threshold);

endmodule

`default_nettype wire

// ----- rtl/lfs_merge.sv -----
// merge of the lane flags: mode register, intersection and position choice
`default_nettype none

module lfs_merge
    import lfs_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    req_type,
    input  wire logic [DIR_W-1:0]        new_direction,
    input  wire logic [LINE_POS_W-1:0]   line_position,
    input  wire logic [SENSOR_COUNT-1:0] on_line,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output steer_req_t                   out_req
);

    logic [DIR_W-1:0] dir_reg, dir_next;
    logic             valid_reg, valid_next;
    steer_req_t       req_reg, req_next;

    logic             accept;
    logic             all_on;
    logic             centred;
    logic [EXT_W-1:0] on_ext;
    logic [DIR_W-1:0] dir_eff;
    logic [POS_W-1:0] right_pos;
    logic [POS_W-1:0] left_pos;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign all_on   = &on_line;
    assign on_ext   = EXT_W'(on_line);
    assign centred  = (line_position > LINE_POS_W'(CENTRE_LOW))
                   && (line_position < LINE_POS_W'(CENTRE_HIGH))
                   && on_ext[2] && on_ext[3] && !on_ext[1] && !on_ext[4];
    assign dir_eff  = centred ? DIR_FOLLOW : dir_reg;

    // highest on-line index wins for right, lowest for left
    always_comb begin
        right_pos = POS_W'(RIGHT_NONE_POS);
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (on_line[i]) begin
                right_pos = index_pos(i);
            end
        end
    end

    always_comb begin
        left_pos = POS_W'(LEFT_NONE_POS);
        for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
            if (on_line[i]) begin
                left_pos = index_pos(i);
            end
        end
    end

    always_comb begin
        dir_next   = dir_reg;
        valid_next = valid_reg;
        req_next   = req_reg;
        if (in_ready) begin
            valid_next = accept && (req_type == REQ_SAMPLE);
        end
        if (accept) begin
            if (req_type == REQ_MODE) begin
                if (new_direction != DIR_KEEP) begin
                    dir_next = new_direction;
                end
            end else if (all_on && dir_reg == DIR_FOLLOW) begin
                req_next.stop = 1'b1;
                req_next.pos  = '0;
            end else begin
                dir_next      = dir_eff;
                req_next.stop = 1'b0;
                if (dir_eff == DIR_RIGHT) begin
                    req_next.pos = right_pos;
                end else if (dir_eff == DIR_LEFT) begin
                    req_next.pos = left_pos;
                end else begin
                    req_next.pos = POS_W'(line_position);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= DIR_FOLLOW;
            valid_reg <= 1'b0;
        end else begin
            dir_reg   <= dir_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;

endmodule

`default_nettype wire

// ----- rtl/lfs_steer.sv -----
// proportional steering and speed saturation with the output register
`default_nettype none

module lfs_steer
    import lfs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire steer_req_t                in_req,
    input  wire logic [TOP_W-1:0]          top_speed,
    input  wire logic signed [SPEED_W-1:0] bottom_speed,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [SPEED_W-1:0]      left_speed,
    output logic signed [SPEED_W-1:0]      right_speed,
    output logic                           intersection_stop
);

    logic                      valid_reg, valid_next;
    logic signed [SPEED_W-1:0] left_reg, left_next;
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic                      stop_reg, stop_next;

    logic signed [SUM_W-1:0] err;
    logic signed [SUM_W-1:0] err_adj;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] top_ext;
    logic signed [SUM_W-1:0] bot_ext;
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sat_l;
    logic signed [SUM_W-1:0] sat_r;

    assign err     = $signed({1'b0, in_req.pos}) - SUM_W'(CENTRE_POS);
    // round toward zero on the divide by four
    assign err_adj = err[SUM_W-1] ? (err + SUM_W'(3)) : err;
    assign diff    = err_adj >>> 2;
    assign top_ext = $signed({{(SUM_W - TOP_W){1'b0}}, top_speed});
    assign bot_ext = SUM_W'(bottom_speed);
    assign sum_l   = top_ext + diff;
    assign sum_r   = top_ext - diff;

    // lower limit first, then upper
    always_comb begin
        sat_l = (sum_l < bot_ext) ? bot_ext : sum_l;
        sat_l = (sat_l > top_ext) ? top_ext : sat_l;
        sat_r = (sum_r < bot_ext) ? bot_ext : sum_r;
        sat_r = (sat_r > top_ext) ? top_ext : sat_r;
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        left_next  = left_reg;
        right_next = right_reg;
        stop_next  = stop_reg;
        if (in_ready) begin
            valid_next = in_valid;
            stop_next  = in_req.stop;
            if (in_req.stop) begin
                left_next  = '0;
                right_next = '0;
            end else begin
                left_next  = SPEED_W'(sat_l);
                right_next = SPEED_W'(sat_r);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
        stop_reg  <= stop_next;
    end

    assign out_valid         = valid_reg;
    assign left_speed        = left_reg;
    assign right_speed       = right_reg;
    assign intersection_stop = stop_reg;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for line_follow_steering_top: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import lfs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_SENSOR = (1 << SENSOR_W) - 1;
    localparam int MAX_POS = (1 << LINE_POS_W) - 1;

    typedef logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] sensor_vec_t;
    typedef logic [DIR_W-1:0] dir_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic                      stop;
    } motor_cmd_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    int unsigned      thr_q = RST_THRESHOLD;
    int               top_q = RST_TOP;
    int               bot_q = RST_BOTTOM;
    logic [DIR_W-1:0] mode_q = DIR_FOLLOW;

    motor_cmd_t motor_cmd_q[$];
    motor_cmd_t got_cmd;
    motor_cmd_t want_cmd;
    int         mismatches = 0;
    int         cycle_cnt = 0;
    int         hold_req = 0;
    bit         sender_idle_en = 1'b1;
    bit         sink_idle_en = 1'b1;

    line_follow_steering_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("line_follow_steering_top: mismatch");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int clamp_speed(int v);
        if (v < bot_q) begin
            v = bot_q;
        end
        if (v > top_q) begin
            v = top_q;
        end
        return v;
    endfunction

    function automatic void predict_steering(input logic req, input logic [DIR_W-1:0] dir,
                                             input sensor_vec_t sens,
                                             input logic [LINE_POS_W-1:0] lpos,
                                             output bit produced, output motor_cmd_t cmd);
        logic [SENSOR_COUNT-1:0] on;
        int p;
        int diff;
        produced = 1'b0;
        cmd = '0;
        if (req == REQ_MODE) begin
            if (dir != DIR_KEEP) begin
                mode_q = dir;
            end
            return;
        end
        produced = 1'b1;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            on[i] = sens[i] > thr_q;
        end
        p = int'(lpos);
        if ((&on) && mode_q == DIR_FOLLOW) begin
            cmd.stop = 1'b1;
            return;
        end
        if (p > CENTRE_LOW && p < CENTRE_HIGH && on[2] && on[3] && !on[1] && !on[4]) begin
            mode_q = DIR_FOLLOW;
        end
        if (mode_q == DIR_RIGHT) begin
            p = RIGHT_NONE_POS;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (on[i]) begin
                    p = i * STEP_POS;
                end
            end
        end else if (mode_q == DIR_LEFT) begin
            p = LEFT_NONE_POS;
            for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
                if (on[i]) begin
                    p = i * STEP_POS;
                end
            end
        end
        diff = (p - CENTRE_POS) / 4;
        cmd.left = SPEED_W'(clamp_speed(top_q + diff));
        cmd.right = SPEED_W'(clamp_speed(top_q - diff));
    endfunction

    // masked sensors go above the threshold unless it is at maximum, the rest at or below it
    function automatic sensor_vec_t pattern_sens(input logic [SENSOR_COUNT-1:0] mask);
        sensor_vec_t s;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (mask[i] && thr_q < MAX_SENSOR) begin
                s[i] = SENSOR_W'($urandom_range(thr_q + 1, MAX_SENSOR));
            end else begin
                s[i] = SENSOR_W'($urandom_range(0, thr_q));
            end
        end
        return s;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_cmd.left = m_tdata[SPEED_W-1:0];
            got_cmd.right = m_tdata[2*SPEED_W-1:SPEED_W];
            got_cmd.stop = m_tuser;
            if (motor_cmd_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: left %0d right %0d stop %0b",
                             got_cmd.left, got_cmd.right, got_cmd.stop);
                end
            end else begin
                want_cmd = motor_cmd_q.pop_front();
                if (got_cmd.left !== want_cmd.left || got_cmd.right !== want_cmd.right
                    || got_cmd.stop !== want_cmd.stop) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("item mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want_cmd.left, want_cmd.right, want_cmd.stop,
                                 got_cmd.left, got_cmd.right, got_cmd.stop);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic req, input logic [DIR_W-1:0] dir,
                             input sensor_vec_t sens, input logic [LINE_POS_W-1:0] lpos);
        logic [IN_TDATA_W-1:0] word;
        bit produced;
        motor_cmd_t cmd;
        word = '0;
        word[DIR_W-1:0] = dir;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            word[DIR_W + i*SENSOR_W +: SENSOR_W] = sens[i];
        end
        word[LPOS_LSB +: LINE_POS_W] = lpos;
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        predict_steering(req, dir, sens, lpos, produced, cmd);
        if (produced) begin
            motor_cmd_q.push_back(cmd);
        end
        if (sender_idle_en && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (idle_len()) @(posedge aclk);
        end
    endtask

    task automatic send_mode(input logic [DIR_W-1:0] dir);
        send_item(REQ_MODE, dir, sensor_vec_t'({$urandom, $urandom}),
                  LINE_POS_W'($urandom));
    endtask

    task automatic send_sample(input logic [SENSOR_COUNT-1:0] mask, input int lpos);
        send_item(REQ_SAMPLE, dir_t'($urandom), pattern_sens(mask), LINE_POS_W'(lpos));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (motor_cmd_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: thr_q = d;
            CFG_TOP:       top_q = int'(d[TOP_W-1:0]);
            CFG_BOTTOM:    bot_q = int'(signed'(d));
            default: ;
        endcase
    endtask

    task automatic apply_config(input int thr, input int top, input int bot);
        wait_idle();
        cfg_write(CFG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(CFG_TOP, CFG_DATA_W'(top));
        cfg_write(CFG_BOTTOM, CFG_DATA_W'(bot));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_defaults();
        send_sample(6'b000000, 0);
        send_sample(6'b000000, MAX_POS);
        send_sample(6'b001100, 2500);
        send_sample(6'b111111, 1234);
        send_sample(6'b010000, 2497);
        send_sample(6'b000010, 2493);
    endtask

    task automatic test_modes();
        send_mode(DIR_RIGHT);
        send_sample(6'b000000, 2500);
        send_sample(6'b010010, 100);
        send_mode(DIR_KEEP);
        send_sample(6'b000001, 4000);
        send_mode(DIR_LEFT);
        send_sample(6'b000000, 4000);
        send_sample(6'b110000, 0);
        send_sample(6'b111111, 3000);
        send_sample(6'b001100, 2999);
        send_sample(6'b111111, 2500);
        send_mode(DIR_RIGHT);
        send_sample(6'b101101, 2001);
        send_mode(DIR_FOLLOW);
    endtask

    task automatic test_speed_limits();
        apply_config(0, 511, -512);
        send_sample(6'b000000, 0);
        send_sample(6'b000000, MAX_POS);
        apply_config(MAX_SENSOR, 0, 0);
        send_sample(6'b111111, 5000);
        apply_config(800, 100, 300);
        send_sample(6'b000000, 2500);
        apply_config(1000, 400, 511);
        send_sample(6'b000100, 4321);
        apply_config(800, 200, -200);
    endtask

    task automatic test_backpressure();
        wait_idle();
        sender_idle_en = 1'b0;
        hold_req = 150;
        for (int i = 0; i < 30; i++) begin
            send_sample(6'(pattern_sens(6'h3f)), $urandom_range(0, 5000));
        end
        wait_idle();
        sender_idle_en = 1'b1;
    endtask

    task automatic randomize_config();
        int thr;
        int top;
        int bot;
        case ($urandom_range(0, 9))
            0: thr = 0;
            1: thr = MAX_SENSOR;
            default: thr = $urandom_range(100, 950);
        endcase
        case ($urandom_range(0, 9))
            0: top = 0;
            1: top = 511;
            default: top = $urandom_range(50, 400);
        endcase
        case ($urandom_range(0, 9))
            0: bot = -512;
            1: bot = $urandom_range(0, 511);
            default: bot = -int'($urandom_range(0, 400));
        endcase
        apply_config(thr, top, bot);
    endtask

    task automatic test_random();
        int r;
        logic [SENSOR_COUNT-1:0] mask;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            randomize_config();
            sink_idle_en = (ph != 2);
            sender_idle_en = (ph != 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                mask = SENSOR_COUNT'($urandom);
                if (r < 12) begin
                    send_mode(dir_t'($urandom_range(0, 3)));
                end else if (r < 22) begin
                    send_sample('1, $urandom_range(0, 5000));
                end else if (r < 37) begin
                    mask[1] = 1'b0;
                    mask[2] = 1'b1;
                    mask[3] = 1'b1;
                    mask[4] = 1'b0;
                    send_sample(mask, $urandom_range(0, 9) == 0 ? $urandom_range(1999, 3001)
                                                                 : $urandom_range(2001, 2999));
                end else if (r < 47) begin
                    send_item(REQ_SAMPLE, dir_t'($urandom),
                              sensor_vec_t'({$urandom, $urandom}), LINE_POS_W'($urandom));
                end else begin
                    send_sample(mask, $urandom_range(0, 5000));
                end
            end
        end
        sink_idle_en = 1'b1;
        sender_idle_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_modes();
        test_speed_limits();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && motor_cmd_q.size() == 0) begin
            $display("line_follow_steering_top: match");
        end else begin
            $display("line_follow_steering_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- line_follow_steering_top.f -----
rtl/lfs_pkg.sv
rtl/lfs_lane.sv
rtl/lfs_merge.sv
rtl/lfs_steer.sv
rtl/line_follow_steering_top.sv
bench/tb_top.sv
